// ===== hw/rtl/gwc_pkg.sv =====
// shared types, codes and defaults for the gaussian window convolution block
`default_nettype none

package gwc_pkg;

   localparam int DEF_MAX_RADIUS = 12;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CMD_W      = 2;
   localparam int PIX_W      = 16;
   localparam int WGT_W      = 16;
   localparam int SLOT_W     = 10;
   localparam int POS_OUT_W  = 10;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_START,
      ST_TAPS,
      ST_DRAIN,
      ST_STORE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gwc_mac.sv =====
// multiply-accumulate of window taps with rounding and saturation
`default_nettype none

module gwc_mac #(
   parameter int ACC_W = 42
) (
   input  wire                    clock,
   input  wire                    reset,
   input  gwc_pkg::mac_ctl_type   ctl,
   input  wire [15:0]             weight,
   input  wire [15:0]             pixel,
   output logic                   busy,
   output logic [15:0]            result
);
   import gwc_pkg::*;

   logic [31:0]      prod_ff;
   logic             prod_v_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W:0]   rounded;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctl.valid;
      end
      prod_ff <= weight * pixel;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      rounded = ({1'b0, acc_ff} + (ACC_W+1)'(32768)) >> 16;
      if (rounded > (ACC_W+1)'(65535)) begin
         result = 16'hffff;
      end else begin
         result = rounded[15:0];
      end
   end

   assign busy = prod_v_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_window_convolution.sv =====
// top level: streaming zero-padded square-kernel convolution over a raster frame
// sequence: a weight load or dropped pixel returns straight to idle, a stored pixel
//   with no result passes through store and check; a result follows setup, start,
//   the tap walk, drain, the store of a pending pixel and emit, one tap per cycle through the single read
//   port of the pixel store and weight memory
// throughput: one request at a time, the next is taken only once the block is idle again
// reset: synchronous, active high; positions cleared, registers to 1024/1024/1,
//   memories are not cleared
`default_nettype none

module gaussian_window_convolution #(
   parameter int MAX_RADIUS = gwc_pkg::DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = gwc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gwc_pkg::DEF_MAX_HEIGHT
) (
   input  wire                              clock,
   input  wire                              reset,
   // request: tuser = cmd; tdata = weight_slot, weight_value, pixel_value
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [gwc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire [gwc_pkg::CMD_W-1:0]         req_tuser,
   // result: tdata = blurred_value, out_row, out_col; tlast = frame_done
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [gwc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   // configuration write port
   input  wire                              csr_wr_en,
   input  wire [gwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [gwc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gwc_pkg::*;

   localparam int SIDE     = 2 * MAX_RADIUS + 1;
   localparam int WT_DEPTH = SIDE * SIDE;
   localparam int WT_AW    = $clog2(WT_DEPTH);
   localparam int ST_DEPTH = SIDE * MAX_WIDTH;
   localparam int ST_AW    = $clog2(ST_DEPTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int HD_W     = $clog2(MAX_HEIGHT + 1);
   localparam int WD_W     = $clog2(MAX_WIDTH + 1);
   localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
   localparam int SIDE_W   = $clog2(SIDE + 1);
   localparam int TR_W     = ROW_W + 2;
   localparam int TC_W     = COL_W + 2;
   localparam int ACC_W    = WT_AW + 32;

   // memories
   logic [WGT_W-1:0] wt_mem [WT_DEPTH];
   logic [PIX_W-1:0] st_mem [ST_DEPTH];
   logic [WGT_W-1:0] wt_rd_ff;
   logic [PIX_W-1:0] st_rd_ff;
   logic             rd_v_ff;

   state_type state_ff, state_in;

   // geometry registers
   logic [WD_W-1:0]  width_ff;
   logic [HD_W-1:0]  height_ff;
   logic [RAD_W-1:0] radius_ff;

   // frame positions
   logic [ROW_W-1:0] in_row_ff, emit_row_ff;
   logic [COL_W-1:0] in_col_ff, emit_col_ff;
   logic [ST_AW-1:0] in_ptr_ff, emit_ptr_ff;
   logic             full_ff;

   // latched request
   logic [CMD_W-1:0] cmd_ff;
   logic [PIX_W-1:0] pix_ff;
   logic             pend_store_ff;

   // tap walk
   logic [ST_AW:0]          rw_ff;
   logic [ST_AW-1:0]        row_step_ff;
   logic [ST_AW-1:0]        tap_ptr_ff;
   logic signed [TR_W-1:0]  tap_row_ff;
   logic signed [TC_W-1:0]  tap_col_ff, col_start_ff;
   logic [SIDE_W-1:0]       tap_j_ff, tap_k_ff;
   logic [WT_AW-1:0]        widx_ff;

   // result register
   logic             rsp_valid_ff;
   logic [15:0]      rsp_val_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic             rsp_last_ff;

   // combinational helpers
   logic             accept;
   logic [REQ_DATA_W-1:0] rd;
   logic [31:0]      slot32;
   logic [31:0]      nr, nc, h_m1, w_m1;
   logic             ready;
   logic [SIDE_W-1:0] side;
   logic             tap_valid;
   logic             last_tap_col, last_tap;
   logic             emit_last;
   logic             emit_fire;
   logic [31:0]      start_sum, step_sum, row_ptr_sum;
   logic [ST_AW-1:0] ptr_inc, in_ptr_inc, emit_ptr_inc;
   logic [CSR_DATA_W-1:0] csr_val;
   mac_ctl_type      mac_ctl;
   logic             mac_busy;
   logic [15:0]      mac_result;

   assign rd     = req_tdata;
   assign slot32 = 32'(rd[SLOT_W-1:0]);
   assign accept = req_tvalid && req_tready;
   assign side   = SIDE_W'({radius_ff, 1'b1});
   assign h_m1   = 32'(height_ff) - 32'd1;
   assign w_m1   = 32'(width_ff) - 32'd1;

   // pending output is ready once its lowest-right in-frame tap has arrived
   always_comb begin
      nr = 32'(emit_row_ff) + 32'(radius_ff);
      nc = 32'(emit_col_ff) + 32'(radius_ff);
      if (nr > h_m1) nr = h_m1;
      if (nc > w_m1) nc = w_m1;
      ready = full_ff || (32'(in_row_ff) > nr) ||
              ((32'(in_row_ff) == nr) && (32'(in_col_ff) > nc));
   end

   assign emit_last = (32'(emit_row_ff) == h_m1) && (32'(emit_col_ff) == w_m1);
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // tap inside the frame
   assign tap_valid = !tap_row_ff[TR_W-1] && !tap_col_ff[TC_W-1] &&
                      (32'($unsigned(tap_row_ff)) < 32'(height_ff)) &&
                      (32'($unsigned(tap_col_ff)) < 32'(width_ff));
   assign last_tap_col = (tap_k_ff == side - SIDE_W'(1));
   assign last_tap     = last_tap_col && (tap_j_ff == side - SIDE_W'(1));

   // ring pointer arithmetic modulo the store depth
   assign start_sum   = 32'(emit_ptr_ff) + 32'(ST_DEPTH) - 32'(rw_ff) - 32'(radius_ff);
   assign step_sum    = 32'(width_ff) + 32'(ST_DEPTH) - 32'({radius_ff, 1'b0});
   assign row_ptr_sum = 32'(tap_ptr_ff) + 32'(row_step_ff);
   assign ptr_inc      = (32'(tap_ptr_ff) == 32'(ST_DEPTH - 1)) ? '0 : tap_ptr_ff + 1'b1;
   assign in_ptr_inc   = (32'(in_ptr_ff) == 32'(ST_DEPTH - 1)) ? '0 : in_ptr_ff + 1'b1;
   assign emit_ptr_inc = (32'(emit_ptr_ff) == 32'(ST_DEPTH - 1)) ? '0 : emit_ptr_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_PIXEL && !full_ff) begin
                  state_in = ready ? ST_SETUP : ST_STORE;
               end else if (req_tuser == CMD_FLUSH && ready) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: state_in = ST_START;
         ST_START: state_in = ST_TAPS;
         ST_TAPS: begin
            if (last_tap) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !mac_busy) state_in = pend_store_ff ? ST_STORE : ST_EMIT;
         end
         ST_STORE: state_in = pend_store_ff ? ST_EMIT : ST_CHECK;
         ST_CHECK: state_in = ready ? ST_SETUP : ST_IDLE;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready    = 1'b0;
      mac_ctl.clear = 1'b0;
      mac_ctl.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready    = 1'b1;
         ST_SETUP: mac_ctl.clear = 1'b1;
         default: begin
         end
      endcase
      mac_ctl.valid = rd_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // weight memory: written on load requests, read during the tap walk
   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_LOAD && slot32 < 32'(WT_DEPTH)) begin
         wt_mem[slot32[WT_AW-1:0]] <= rd[SLOT_W+WGT_W-1:SLOT_W];
      end
      wt_rd_ff <= wt_mem[widx_ff];
   end

   // pixel store ring
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         st_mem[in_ptr_ff] <= pix_ff;
      end
      st_rd_ff <= st_mem[tap_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= (state_ff == ST_TAPS) && tap_valid;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser;
         pix_ff <= rd[SLOT_W+WGT_W+PIX_W-1:SLOT_W+WGT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_store_ff <= 1'b0;
      end else if (accept) begin
         pend_store_ff <= (req_tuser == CMD_PIXEL) && !full_ff && ready;
      end else if (state_ff == ST_STORE) begin
         pend_store_ff <= 1'b0;
      end
   end

   // tap walk over the window, one tap per cycle
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_SETUP: begin
            rw_ff       <= (ST_AW+1)'(32'(radius_ff) * 32'(width_ff));
            row_step_ff <= (step_sum >= 32'(ST_DEPTH)) ? ST_AW'(step_sum - 32'(ST_DEPTH))
                                                       : ST_AW'(step_sum);
         end
         ST_START: begin
            tap_ptr_ff   <= (start_sum >= 32'(ST_DEPTH)) ? ST_AW'(start_sum - 32'(ST_DEPTH))
                                                         : ST_AW'(start_sum);
            tap_row_ff   <= $signed(TR_W'(emit_row_ff)) - $signed(TR_W'(radius_ff));
            tap_col_ff   <= $signed(TC_W'(emit_col_ff)) - $signed(TC_W'(radius_ff));
            col_start_ff <= $signed(TC_W'(emit_col_ff)) - $signed(TC_W'(radius_ff));
            tap_j_ff     <= '0;
            tap_k_ff     <= '0;
            widx_ff      <= '0;
         end
         ST_TAPS: begin
            widx_ff <= widx_ff + 1'b1;
            if (last_tap_col) begin
               tap_k_ff   <= '0;
               tap_j_ff   <= tap_j_ff + 1'b1;
               tap_row_ff <= tap_row_ff + TR_W'(1);
               tap_col_ff <= col_start_ff;
               tap_ptr_ff <= (row_ptr_sum >= 32'(ST_DEPTH))
                             ? ST_AW'(row_ptr_sum - 32'(ST_DEPTH)) : ST_AW'(row_ptr_sum);
            end else begin
               tap_k_ff   <= tap_k_ff + 1'b1;
               tap_col_ff <= tap_col_ff + TC_W'(1);
               tap_ptr_ff <= ptr_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // geometry registers, positions and frame flag
   always_comb begin
      csr_val = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WD_W'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
         height_ff   <= HD_W'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
         radius_ff   <= RAD_W'(1);
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
         in_ptr_ff   <= '0;
         emit_ptr_ff <= '0;
         full_ff     <= 1'b0;
      end else if (csr_wr_en && (csr_index inside {CSR_WIDTH, CSR_HEIGHT, CSR_RADIUS})) begin
         unique case (csr_index)
            CSR_WIDTH: begin
               if (csr_val == '0) width_ff <= WD_W'(1);
               else if (32'(csr_val) > 32'(MAX_WIDTH)) width_ff <= WD_W'(MAX_WIDTH);
               else width_ff <= WD_W'(csr_val);
            end
            CSR_HEIGHT: begin
               if (csr_val == '0) height_ff <= HD_W'(1);
               else if (32'(csr_val) > 32'(MAX_HEIGHT)) height_ff <= HD_W'(MAX_HEIGHT);
               else height_ff <= HD_W'(csr_val);
            end
            default: begin
               if (32'(csr_val[3:0]) > 32'(MAX_RADIUS)) radius_ff <= RAD_W'(MAX_RADIUS);
               else radius_ff <= RAD_W'(csr_val[3:0]);
            end
         endcase
         // any geometry write restarts the frame
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
         in_ptr_ff   <= '0;
         emit_ptr_ff <= '0;
         full_ff     <= 1'b0;
      end else begin
         if (state_ff == ST_STORE) begin
            in_ptr_ff <= in_ptr_inc;
            if (32'(in_col_ff) == w_m1) begin
               in_col_ff <= '0;
               if (32'(in_row_ff) == h_m1) begin
                  in_row_ff <= '0;
                  full_ff   <= 1'b1;
               end else begin
                  in_row_ff <= in_row_ff + 1'b1;
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (emit_fire) begin
            if (emit_last) begin
               // last result of the frame: start the next one
               in_row_ff   <= '0;
               in_col_ff   <= '0;
               emit_row_ff <= '0;
               emit_col_ff <= '0;
               in_ptr_ff   <= '0;
               emit_ptr_ff <= '0;
               full_ff     <= 1'b0;
            end else begin
               emit_ptr_ff <= emit_ptr_inc;
               if (32'(emit_col_ff) == w_m1) begin
                  emit_col_ff <= '0;
                  emit_row_ff <= emit_row_ff + 1'b1;
               end else begin
                  emit_col_ff <= emit_col_ff + 1'b1;
               end
            end
         end
      end
   end

   gwc_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .weight (wt_rd_ff),
      .pixel  (st_rd_ff),
      .busy   (mac_busy),
      .result (mac_result)
   );

   // output register, holds a result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_val_ff  <= mac_result;
         rsp_row_ff  <= emit_row_ff;
         rsp_col_ff  <= emit_col_ff;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, POS_OUT_W'(rsp_col_ff), POS_OUT_W'(rsp_row_ff), rsp_val_ff};

   // checks
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && !emit_fire |=> rsp_valid_ff && $stable(rsp_val_ff))
      else $error("result dropped while stalled");

   a_tap_ptr_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAPS |-> 32'(tap_ptr_ff) < 32'(ST_DEPTH))
      else $error("tap pointer outside pixel store");

   a_emit_behind_in: assert property (@(posedge clock) disable iff (reset)
      !full_ff |-> (in_row_ff > emit_row_ff) ||
                   (in_row_ff == emit_row_ff && in_col_ff >= emit_col_ff))
      else $error("emit position ahead of received pixels");

   a_store_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE |-> cmd_ff == CMD_PIXEL)
      else $error("pixel store written without a pixel request");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the gaussian window convolution block: random frames checked against a predictor
`default_nettype none

module tb_top;
   import gwc_pkg::*;

   localparam int KSIDE      = 2 * DEF_MAX_RADIUS + 1;
   localparam int WT_DEPTH   = KSIDE * KSIDE;
   localparam int RING_DEPTH = KSIDE * DEF_MAX_WIDTH;
   localparam int HOLD_OFF   = 700;      // longer than the worst tap loop plus pipeline slack
   localparam int CYCLE_LIMIT = 10000000;
   localparam int ITEM_GOAL  = 1550;

   // tracks the block's frame state and predicts each filtered pixel
   class blur_tracker_type;
      typedef struct {
         logic [15:0] value;
         logic [9:0]  row;
         logic [9:0]  col;
         logic        last;
      } blurred_pixel_type;

      logic [15:0]  taps[WT_DEPTH];
      logic [15:0]  ring[RING_DEPTH];
      int unsigned  width = 1024, height = 1024, radius = 1;
      int unsigned  in_row, in_col, out_row, out_col;
      bit           frame_full;
      blurred_pixel_type expected_pixels[$];
      int           mismatches, results;

      function void restart();
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         frame_full = 0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         int unsigned v;
         v = val;
         case (idx)
            CSR_WIDTH:  width  = (v < 1) ? 1 : (v > DEF_MAX_WIDTH)  ? DEF_MAX_WIDTH  : v;
            CSR_HEIGHT: height = (v < 1) ? 1 : (v > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : v;
            CSR_RADIUS: radius = (v[3:0] > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : v[3:0];
            default: return;
         endcase
         restart();
      endfunction

      function bit pending_ready();
         int unsigned nr, nc;
         if (frame_full) return 1;
         nr = out_row + radius;
         nc = out_col + radius;
         if (nr > height - 1) nr = height - 1;
         if (nc > width - 1) nc = width - 1;
         return in_row > nr || (in_row == nr && in_col > nc);
      endfunction

      function logic [15:0] window_sum();
         longint unsigned acc;
         int rr, cc, side;
         acc = 0;
         side = 2 * radius + 1;
         for (int dr = -int'(radius); dr <= int'(radius); dr++) begin
            rr = int'(out_row) + dr;
            if (rr < 0 || rr >= int'(height)) continue;
            for (int dc = -int'(radius); dc <= int'(radius); dc++) begin
               cc = int'(out_col) + dc;
               if (cc < 0 || cc >= int'(width)) continue;
               acc += longint'(taps[(dr + radius) * side + dc + radius])
                      * ring[(rr * width + cc) % RING_DEPTH];
            end
         end
         acc = (acc + 32768) >> 16;
         return (acc > 65535) ? 16'hFFFF : acc[15:0];
      endfunction

      function void emit(logic [15:0] val);
         blurred_pixel_type p;
         p.value = val;
         p.row   = out_row[9:0];
         p.col   = out_col[9:0];
         p.last  = (out_row == height - 1) && (out_col == width - 1);
         expected_pixels.insert(expected_pixels.size(), p);
         if (p.last) restart();
         else if (++out_col >= width) begin
            out_col = 0;
            out_row++;
         end
      endfunction

      // accepted request: update state, queue the pixel it produces if any
      function void note_request(logic [CMD_W-1:0] cmd, logic [9:0] slot,
                                 logic [15:0] wval, logic [15:0] pix);
         bit ready_early;
         logic [15:0] val;
         case (cmd)
            CMD_LOAD: if (slot < WT_DEPTH) taps[slot] = wval;
            CMD_PIXEL: begin
               if (frame_full) return;
               ready_early = pending_ready();
               if (ready_early) val = window_sum();
               ring[(in_row * width + in_col) % RING_DEPTH] = pix;
               if (++in_col >= width) begin
                  in_col = 0;
                  if (++in_row >= height) begin
                     in_row = 0;
                     frame_full = 1;
                  end
               end
               if (ready_early) emit(val);
               else if (pending_ready()) emit(window_sum());
            end
            CMD_FLUSH: if (pending_ready()) emit(window_sum());
            default: ;
         endcase
      endfunction

      function void check_result(logic [15:0] val, logic [9:0] row, logic [9:0] col,
                                 logic last);
         blurred_pixel_type p;
         results++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %h row %0d col %0d last %b",
                        val, row, col, last);
            return;
         end
         p = expected_pixels.pop_front();
         if (val !== p.value || row !== p.row || col !== p.col || last !== p.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h r%0d c%0d l%b, got %h r%0d c%0d l%b",
                        p.value, p.row, p.col, p.last, val, row, col, last);
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // weight_slot, weight_value, pixel_value
   logic [CMD_W-1:0]      req_tuser = CMD_LOAD;  // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // blurred_value, out_row, out_col
   logic                  rsp_tlast;        // frame_done
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   blur_tracker_type tracker = new();
   int  requests_sent;
   int  frames_run;
   int  cycle_count;
   bit  quiet;          // no idling on either side near the end

   gaussian_window_convolution dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // result side: check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata[15:0], rsp_tdata[25:16], rsp_tdata[35:26], rsp_tlast);
   end

   // result side back-pressure in random bursts
   initial begin
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // one request; returns at the edge that accepted it, with tvalid still high
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [9:0] slot,
                               logic [15:0] wval, logic [15:0] pix);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, pix, wval, slot};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(cmd, slot, wval, pix);
      requests_sent++;
   endtask

   // stop sending until all results are back, then let the tap loop settle
   task automatic drain();
      req_tvalid <= 0;
      while (tracker.expected_pixels.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.configure(idx, val);
      csr_wr_en <= 0;
   endtask

   task automatic set_geometry(int w, int h, int r);
      drain();
      write_csr(CSR_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_RADIUS, CSR_DATA_W'(r));
   endtask

   // random weight value, mostly small so results stay in range
   function automatic logic [15:0] rand_weight();
      return ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
   endfunction

   // one full frame, with noise mixed in when noisy is set, then flushes until the frame closes
   task automatic run_frame(int npix, bit noisy);
      for (int i = 0; i < npix; i++) begin
         if (noisy) begin
            case ($urandom_range(0, 31))
               0, 1: send_request(CMD_LOAD, 10'($urandom_range(0, WT_DEPTH - 1)),
                                  rand_weight(), 16'($urandom));
               2: send_request(CMD_LOAD, 10'($urandom_range(WT_DEPTH, 1023)),
                               16'($urandom), 16'($urandom));
               3: send_request(CMD_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom));
               4, 5: send_request(CMD_FLUSH, 10'($urandom), 16'($urandom), 16'($urandom));
               default: ;
            endcase
         end
         send_request(CMD_PIXEL, 10'($urandom), 16'($urandom), 16'($urandom));
      end
      // a pixel while outputs are still pending is dropped
      if (tracker.frame_full && noisy)
         send_request(CMD_PIXEL, 10'($urandom), 16'($urandom), 16'($urandom));
      while (tracker.frame_full)
         send_request(CMD_FLUSH, 10'($urandom), 16'($urandom), 16'($urandom));
      frames_run++;
   endtask

   initial begin
      int w, h, r;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill the whole weight table so no unwritten tap is ever read
      for (int s = 0; s < WT_DEPTH; s++)
         send_request(CMD_LOAD, 10'(s),
                      (s == 0) ? 16'h0 : (s == 1) ? 16'hFFFF : rand_weight(),
                      16'($urandom));

      // single-pixel frame from clamped zero geometry, largest pixel
      set_geometry(0, 0, 0);
      send_request(CMD_FLUSH, 10'h0, 16'h0, 16'h0);      // nothing pending yet
      send_request(CMD_PIXEL, 10'h0, 16'h0, 16'hFFFF);

      // 3x3 saturating frame: full weights, random pixels, plus ignored commands
      set_geometry(3, 3, 1);
      for (int s = 0; s < 9; s++) send_request(CMD_LOAD, 10'(s), 16'hFFFF, 16'h0);
      send_request(CMD_LOAD, 10'h3FF, 16'h1234, 16'h0);
      send_request(CMD_UNUSED, 10'h3FF, 16'hFFFF, 16'hFFFF);
      run_frame(9, 0);

      // clamped maximum geometry and radius: a few pixels, no result yet
      set_geometry(11'h7FF, 1024, 15);
      for (int i = 0; i < 6; i++)
         send_request(CMD_PIXEL, 10'h0, 16'h0, (i == 0) ? 16'h0 : 16'($urandom));
      send_request(CMD_FLUSH, 10'h0, 16'h0, 16'h0);

      // one-column and one-row frames, the second with the widest kernel
      set_geometry(1, 40, 0);
      run_frame(40, 1);
      set_geometry(30, 1, 12);
      run_frame(30, 1);

      // random frames; the sender holds off mid-frame once
      while (requests_sent < ITEM_GOAL) begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 10);
         r = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
         set_geometry(w, h, r);
         if (frames_run == 10) begin
            for (int i = 0; i < w * h / 2; i++)
               send_request(CMD_PIXEL, 10'h0, 16'h0, 16'($urandom));
            drain();
            run_frame(w * h - w * h / 2, 1);
         end else
            run_frame(w * h, 1);
         if (requests_sent > ITEM_GOAL - 200) quiet = 1;
      end

      req_tvalid <= 0;
      while (tracker.expected_pixels.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);

      $display("ran %0d frames, %0d requests, %0d filtered pixels checked",
               frames_run, requests_sent, tracker.results);
      if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0)
         $display("status: pass");
      else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
